// ----- design/fspa_pkg.sv -----
// Shared types and constants for the fixed slot pool allocator.
`default_nettype none

package fspa_pkg;

  // Default pool capacity
  localparam int unsigned SLOT_COUNT_DEF = 512;

  // Fixed payload widths
  localparam int unsigned SLOT_IN_W   = 10;
  localparam int unsigned SLOT_OUT_W  = 9;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 10;
  localparam int unsigned WAITS_W     = 32;

  // Request kinds
  typedef enum logic {
    REQ_ACQUIRE = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FOREIGN   = 2'd2,
    ST_NOT_OWNED = 2'd3
  } status_e;

  // One result item, handed from the control unit to the output register
  typedef struct packed {
    logic                   granted;
    logic [SLOT_OUT_W-1:0]  slot_out;
    status_e                status;
    logic [COUNT_OUT_W-1:0] used_now;
    logic [COUNT_OUT_W-1:0] used_peak;
    logic [WAITS_W-1:0]     empty_waits;
  } fspa_res_t;

endpackage

`default_nettype wire

// ----- design/fspa_slot_ram.sv -----
// Slot table memory: one write port, one read port with registered read data.
`default_nettype none

module fspa_slot_ram #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned WIDTH  = 11,
  parameter int unsigned ADDR_W = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/fspa_ctrl.sv -----
// Allocator control: request sequencing, free-list head, counters and table updates.
`default_nettype none

module fspa_ctrl #(
  parameter int unsigned SLOT_COUNT = 512,
  parameter int unsigned IDX_W      = 9,
  parameter int unsigned LINK_W     = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request side
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           req_type_i,
  input  wire logic [fspa_pkg::SLOT_IN_W-1:0] slot_in_i,
  // result side
  input  wire logic                           res_ready_i,
  output logic                                res_valid_o,
  output fspa_pkg::fspa_res_t                 res_o,
  // slot table
  output logic                                rd_en_o,
  output logic [IDX_W-1:0]                    rd_addr_o,
  input  wire logic [LINK_W:0]                rd_data_i,
  output logic                                wr_en_o,
  output logic [IDX_W-1:0]                    wr_addr_o,
  output logic [LINK_W:0]                     wr_data_o
);

  import fspa_pkg::*;

  localparam int unsigned CNT_W = LINK_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e             state_q, state_d;
  logic [LINK_W-1:0]  top_q, top_d;      // slot + 1 of the stack head, zero when empty
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   peak_q, peak_d;
  logic [CNT_W-1:0]   fresh_q, fresh_d;  // slots at or above this were never popped
  logic [WAITS_W-1:0] waits_q, waits_d;
  logic               kind_q, kind_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               foreign_q, foreign_d;

  logic [31:0]       slot_ext;
  logic [31:0]       top_m1_ext;
  logic [IDX_W-1:0]  pick;
  logic              accept;
  logic              pool_empty;
  logic              pick_fresh;
  logic              rel_fresh;
  logic [31:0]       init_link_ext;
  logic [LINK_W-1:0] next_top;
  logic              slot_owned;
  logic [31:0]       count_inc_ext;
  logic [CNT_W-1:0]  count_inc;
  logic [31:0]       pick_out_ext;
  logic [31:0]       count_out_ext;
  logic [31:0]       peak_out_ext;

  // Index arithmetic
  assign slot_ext      = 32'(slot_in_i);
  assign top_m1_ext    = 32'(top_q) - 32'd1;
  assign pick          = top_m1_ext[IDX_W-1:0];
  assign accept        = in_valid_i && in_ready_o;
  assign in_ready_o    = (state_q == S_IDLE);

  // Untouched entries read as their reset value
  assign pool_empty    = (top_q == '0) || (32'(top_q) > SLOT_COUNT);
  assign pick_fresh    = 32'(pick) >= 32'(fresh_q);
  assign rel_fresh     = 32'(idx_q) >= 32'(fresh_q);
  assign init_link_ext = (32'(pick) + 32'd1 < SLOT_COUNT) ? 32'(pick) + 32'd2 : 32'd0;
  assign next_top      = pick_fresh ? init_link_ext[LINK_W-1:0] : rd_data_i[LINK_W-1:0];
  assign slot_owned    = rel_fresh ? 1'b0 : rd_data_i[LINK_W];
  assign count_inc_ext = 32'(count_q) + 32'd1;
  assign count_inc     = count_inc_ext[CNT_W-1:0];

  // Table read is issued with the transfer
  assign rd_en_o   = accept;
  assign rd_addr_o = (req_type_i == REQ_ACQUIRE) ? pick : slot_ext[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    count_d      = count_q;
    peak_d       = peak_q;
    fresh_d      = fresh_q;
    waits_d      = waits_q;
    kind_d       = kind_q;
    idx_d        = idx_q;
    foreign_d    = foreign_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = pick;
    wr_data_o    = {1'b1, next_top};
    res_valid_o  = 1'b0;
    pick_out_ext = 32'd0;

    res_o             = '0;
    res_o.status      = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d    = req_type_i;
          idx_d     = slot_ext[IDX_W-1:0];
          foreign_d = slot_ext >= SLOT_COUNT;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          case (kind_q)
            REQ_ACQUIRE: begin
              if (pool_empty) begin
                res_o.status = ST_EMPTY;
                if (waits_q != '1) begin
                  waits_d = waits_q + 1'b1;
                end
              end else begin
                wr_en_o       = 1'b1;
                wr_addr_o     = pick;
                wr_data_o     = {1'b1, next_top};
                top_d         = next_top;
                count_d       = count_inc;
                if (count_inc > peak_q) begin
                  peak_d = count_inc;
                end
                // fill mark moves past the slot just taken
                if (pick_fresh) begin
                  fresh_d = CNT_W'(32'(pick) + 32'd1);
                end
                res_o.granted = 1'b1;
                pick_out_ext  = 32'(pick);
              end
            end
            REQ_RELEASE: begin
              if (foreign_q) begin
                res_o.status = ST_FOREIGN;
              end else if (!slot_owned) begin
                res_o.status = ST_NOT_OWNED;
              end else begin
                wr_en_o   = 1'b1;
                wr_addr_o = idx_q;
                wr_data_o = {1'b0, top_q};
                top_d     = LINK_W'(32'(idx_q) + 32'd1);
                if (count_q != '0) begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            default: begin
              res_o.status = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Counters as they stand after this request
    count_out_ext     = 32'(count_d);
    peak_out_ext      = 32'(peak_d);
    res_o.slot_out    = pick_out_ext[SLOT_OUT_W-1:0];
    res_o.used_now    = count_out_ext[COUNT_OUT_W-1:0];
    res_o.used_peak   = peak_out_ext[COUNT_OUT_W-1:0];
    res_o.empty_waits = waits_d;
  end

  // State and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      top_q     <= LINK_W'(1);
      count_q   <= '0;
      peak_q    <= '0;
      fresh_q   <= '0;
      waits_q   <= '0;
      kind_q    <= REQ_ACQUIRE;
      idx_q     <= '0;
      foreign_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      top_q     <= top_d;
      count_q   <= count_d;
      peak_q    <= peak_d;
      fresh_q   <= fresh_d;
      waits_q   <= waits_d;
      kind_q    <= kind_d;
      idx_q     <= idx_d;
      foreign_q <= foreign_d;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= SLOT_COUNT)
    else $error("owned count above capacity");

  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= count_q)
    else $error("peak below owned count");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fresh_q) <= SLOT_COUNT) && (32'(top_q) <= SLOT_COUNT))
    else $error("fill mark or stack head out of range");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == S_EXEC) && res_valid_o)
    else $error("table write outside an executing request");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.granted) |-> (res_o.status == ST_OK))
    else $error("grant with error status");

endmodule

`default_nettype wire

// ----- design/fixed_slot_pool_allocator_core.sv -----
// Top level of the fixed slot pool allocator: slot table, control and result register.
//
//  Channel  Handshake                 Payload
//  in       in_valid_i / in_ready_o   req_type_i, slot_in_i
//  out      out_valid_o / out_ready_i granted_o, slot_out_o, status_o, used_now_o,
//                                     used_peak_o, empty_waits_o
//
//  Each request has two steps: the transfer issues the slot table read, and the
//  update is applied in the execute state once the registered table data returns.
//  After reset the pool is usable at once: untouched table entries are covered by a
//  fill mark, so no clearing pass runs.
//  A full result register holds the update cycle until out_ready_i takes the result.
`default_nettype none

module fixed_slot_pool_allocator_core #(
  parameter int unsigned SLOT_COUNT = fspa_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             req_type_i,
  input  wire logic [fspa_pkg::SLOT_IN_W-1:0]   slot_in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  granted_o,
  output logic [fspa_pkg::SLOT_OUT_W-1:0]       slot_out_o,
  output logic [fspa_pkg::STATUS_W-1:0]         status_o,
  output logic [fspa_pkg::COUNT_OUT_W-1:0]      used_now_o,
  output logic [fspa_pkg::COUNT_OUT_W-1:0]      used_peak_o,
  output logic [fspa_pkg::WAITS_W-1:0]          empty_waits_o
);

  import fspa_pkg::*;

  localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned LINK_W = $clog2(SLOT_COUNT + 1);

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [LINK_W:0]   rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [LINK_W:0]   wr_data;
  logic              res_valid;
  logic              res_ready;
  fspa_res_t         res;
  logic              out_valid_q, out_valid_d;
  fspa_res_t         out_q;

  // Slot table: owned bit over link
  fspa_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (LINK_W + 1),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  fspa_ctrl #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W     (IDX_W),
    .LINK_W    (LINK_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .slot_in_i  (slot_in_i),
    .res_ready_i(res_ready),
    .res_valid_o(res_valid),
    .res_o      (res),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // Result register: free when empty or drained this cycle
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = res_valid || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign granted_o     = out_q.granted;
  assign slot_out_o    = out_q.slot_out;
  assign status_o      = out_q.status;
  assign used_now_o    = out_q.used_now;
  assign used_peak_o   = out_q.used_peak;
  assign empty_waits_o = out_q.empty_waits;

  // Checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || out_ready_i))
    else $error("result produced while result register is held");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken before the first completed");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> ##1 out_valid_o)
    else $error("result missing two cycles after an unblocked transfer");

endmodule

`default_nettype wire
